/* hdl/twa_pkg.sv */
package twa_pkg;

   localparam int SAMPLE_W       = 16;
   localparam int WIN_W          = 5;
   localparam int MAX_WINDOW_DEF = 16;
   localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(8);

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [WIN_W-1:0]    win;
   } twa_item_type;

   function automatic int win_limit(input int max_window);
      int lim;
      lim = (max_window < 31) ? max_window : 31;
      return lim;
   endfunction

endpackage

/* hdl/twa_channels.sv */
interface twa_req_if;
   import twa_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface twa_rsp_if;
   import twa_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] average;
   modport source (output valid, output average, input ready);
   modport sink   (input valid, input average, output ready);
endinterface

interface twa_csr_if;
   import twa_pkg::*;
   logic             valid;
   logic             ready;
   logic [WIN_W-1:0] window_length;
   modport source (output valid, output window_length, input ready);
   modport sink   (input valid, input window_length, output ready);
endinterface

/* hdl/twa_front.sv */
module twa_front import twa_pkg::*; #(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
   input  logic         clock,
   input  logic         reset,
   twa_req_if.sink      req_bus,
   twa_csr_if.sink      csr_bus,
   input  logic         push_full,
   output logic         push_valid,
   output twa_item_type push_item
);

   localparam int WinMax = win_limit(MAX_WINDOW);

   logic [WIN_W-1:0] window_ff;
   logic [WIN_W-1:0] window_in;
   logic [WIN_W-1:0] eff_win;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = ~push_full;
   assign push_valid    = req_bus.valid & ~push_full;

   always_comb begin
      window_in = window_ff;
      if (csr_bus.valid) begin
         window_in = csr_bus.window_length;
      end
   end

   // zero saturates up to one, anything past the line depth saturates down
   always_comb begin
      if (window_ff == '0) begin
         eff_win = WIN_W'(1);
      end else if (window_ff > WIN_W'(WinMax)) begin
         eff_win = WIN_W'(WinMax);
      end else begin
         eff_win = window_ff;
      end
   end

   assign push_item.sample = req_bus.sample;
   assign push_item.win    = eff_win;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else begin
         window_ff <= window_in;
      end
   end

endmodule

/* hdl/twa_queue.sv */
module twa_queue import twa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   input  twa_item_type push_item,
   output logic         push_full,
   output logic         pop_valid,
   output twa_item_type pop_item,
   input  logic         pop_ready
);

   twa_item_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         do_push, do_pop;

   assign push_full = count_ff[1];
   assign pop_valid = count_ff != 2'd0;
   assign pop_item  = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid & ~push_full;
   assign do_pop    = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* hdl/twa_back.sv */
module twa_back import twa_pkg::*; #(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         pop_valid,
   input  twa_item_type pop_item,
   output logic         pop_ready,
   twa_rsp_if.source    rsp_bus
);

   localparam int WinMax = win_limit(MAX_WINDOW);
   localparam int Depth  = WinMax + 1;
   localparam int IdxW   = $clog2(Depth);
   localparam int SumW   = SAMPLE_W + $clog2(Depth);
   localparam int NumW   = SumW + 1;
   localparam int DivW   = IdxW + 1;
   localparam int CntW   = $clog2(NumW);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_PREP,
      ST_DIVIDE,
      ST_OUT
   } state_type;

   state_type           state_ff, state_in;
   logic [SAMPLE_W-1:0] hist_ff [Depth];
   logic [SAMPLE_W-1:0] hist_in [Depth];
   logic [IdxW-1:0]     idx_ff, idx_in;
   logic [IdxW-1:0]     win_ff, win_in;
   logic [SumW-1:0]     sum_ff, sum_in;
   logic [SAMPLE_W-1:0] oldest_ff, oldest_in;
   logic [NumW-1:0]     num_ff, num_in;
   logic [DivW-1:0]     rem_ff, rem_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] avg_ff, avg_in;
   logic [SAMPLE_W-1:0] tap;
   logic [DivW-1:0]     divisor;
   logic [DivW:0]       trial;
   logic                trial_ok;

   assign tap      = hist_ff[idx_ff];
   assign divisor  = {win_ff, 1'b0};
   assign trial    = {rem_ff, num_ff[NumW-1]};
   assign trial_ok = trial >= {1'b0, divisor};

   assign pop_ready       = state_ff == ST_IDLE;
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.average = avg_ff;

   always_comb begin
      state_in     = state_ff;
      hist_in      = hist_ff;
      idx_in       = idx_ff;
      win_in       = win_ff;
      sum_in       = sum_ff;
      oldest_in    = oldest_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      avg_in       = avg_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_bus.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               hist_in[0] = pop_item.sample;
               for (int k = 1; k < Depth; k++) begin
                  hist_in[k] = hist_ff[k-1];
               end
               win_in   = pop_item.win[IdxW-1:0];
               idx_in   = '0;
               sum_in   = '0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            sum_in = sum_ff + SumW'(tap);
            idx_in = idx_ff + IdxW'(1);
            if (idx_ff == win_ff) begin
               oldest_in = tap;
               state_in  = ST_PREP;
            end
         end
         ST_PREP: begin
            // twice the area: ends once, inner samples twice
            num_in   = {sum_ff, 1'b0} - NumW'(hist_ff[0]) - NumW'(oldest_ff);
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (trial_ok) begin
               rem_in = DivW'(trial - {1'b0, divisor});
            end else begin
               rem_in = trial[DivW-1:0];
            end
            num_in = {num_ff[NumW-2:0], trial_ok};
            cnt_in = cnt_ff + CntW'(1);
            if (cnt_ff == CntW'(NumW - 1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               avg_in       = num_ff[SAMPLE_W-1:0];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      win_ff    <= win_in;
      sum_ff    <= sum_in;
      oldest_ff <= oldest_in;
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
      avg_ff    <= avg_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < Depth; k++) begin
            hist_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         hist_ff      <= hist_in;
      end
   end

endmodule

/* hdl/trapezoid_window_average.sv */
// Trapezoidal moving average over a line of unsigned 16-bit samples.
// req_bus: one sample per beat (valid/ready). rsp_bus: one average per
// request beat, in order. csr_bus: window length write, always ready, to be
// written only while no request is in flight; values of zero saturate to one
// and values beyond the line depth saturate to it.
// Each request shifts the line, sums the window one tap a cycle, forms twice
// the trapezoid area and divides it by twice the window in a restoring
// divider, one quotient bit a cycle.
// Path from request beat to response valid: the queue, the back end's sum
// over window + 1 taps, set-up, the 22-bit divide and output; the back end
// takes the next request the cycle after the previous one is loaded into the
// output register, so it does not take a new request before it is through
// with the last.
// A two-entry queue takes requests while the back end is busy.
// Reset clears the sample line to zeros, the window to 8 and all valids.
// A stalled response holds in the output register and the back end waits;
// once the queue holds two requests, req_bus.ready drops.
module trapezoid_window_average import twa_pkg::*; #(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
   input  logic      clock,
   input  logic      reset,
   twa_req_if.sink   req_bus,
   twa_csr_if.sink   csr_bus,
   twa_rsp_if.source rsp_bus
);

   logic         push_valid, push_full;
   twa_item_type push_item;
   logic         pop_valid, pop_ready;
   twa_item_type pop_item;

   twa_front #(.MAX_WINDOW(MAX_WINDOW)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_bus    (csr_bus),
      .push_full  (push_full),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   twa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_full  (push_full),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   twa_back #(.MAX_WINDOW(MAX_WINDOW)) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop_ready (pop_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;
   import twa_pkg::*;

   class average_scoreboard;
      logic [SAMPLE_W-1:0] line_taps [0:MAX_WINDOW_DEF];
      logic [WIN_W-1:0]    window_reg;
      logic [SAMPLE_W-1:0] pending_averages [$];
      int                  errors;
      int                  checked;

      function new();
         foreach (line_taps[k]) line_taps[k] = '0;
         window_reg = WINDOW_RESET;
         errors     = 0;
         checked    = 0;
      endfunction

      function void set_window(logic [WIN_W-1:0] value);
         window_reg = value;
      endfunction

      // shift the line at full depth, then average the trapezoids over the window
      function void note_sample(logic [SAMPLE_W-1:0] sample);
         int unsigned w;
         int          k;
         logic [21:0] total;
         logic [21:0] twice_area;
         for (k = MAX_WINDOW_DEF; k > 0; k--) line_taps[k] = line_taps[k-1];
         line_taps[0] = sample;
         w = (window_reg == 0) ? 1 :
             (window_reg > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : window_reg;
         total = '0;
         for (k = 0; k <= int'(w); k++) total += line_taps[k];
         twice_area = (total << 1) - line_taps[0] - line_taps[w];
         pending_averages.push_back(SAMPLE_W'(twice_area / (2 * w)));
      endfunction

      function void check_average(logic [SAMPLE_W-1:0] average);
         logic [SAMPLE_W-1:0] want;
         if (pending_averages.size() == 0) begin
            $error("average: unexpected beat, actual %0d", average);
            errors++;
            return;
         end
         want = pending_averages.pop_front();
         checked++;
         if (average !== want) begin
            $error("average: expected %0d, actual %0d", want, average);
            errors++;
         end
      endfunction

      function int pending();
         return pending_averages.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   idle_on = 1'b1;
   int   windows_used = 0;
   average_scoreboard sb;

   twa_req_if req_bus ();
   twa_csr_if csr_bus ();
   twa_rsp_if rsp_bus ();

   trapezoid_window_average uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .csr_bus (csr_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // response sink with random stall bursts while idle_on is set
   int stall_left = 0;
   always @(posedge clock) begin
      logic next_ready;
      if (!idle_on) begin
         next_ready = 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         next_ready = 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 4) == 0) begin
         next_ready = 1'b0;
         stall_left = $urandom_range(0, 4);
      end else begin
         next_ready = 1'b1;
      end
      rsp_bus.ready <= next_ready;
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) sb.check_average(rsp_bus.average);
   end

   task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.sample <= sample;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_sample(sample);
   endtask

   task automatic drain_averages();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_window(input logic [WIN_W-1:0] value);
      drain_averages();
      csr_bus.valid         <= 1'b1;
      csr_bus.window_length <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      sb.set_window(value);
      windows_used++;
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return SAMPLE_W'($urandom_range(0, 15));
         3:       return SAMPLE_W'(16'hFFFF - $urandom_range(0, 15));
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      logic [WIN_W-1:0] corner_windows [7];
      int sent;
      int phase;
      int phase_len;
      int k;
      corner_windows = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd2, 5'd15};
      sb = new();
      req_bus.valid         = 1'b0;
      req_bus.sample        = '0;
      csr_bus.valid         = 1'b0;
      csr_bus.window_length = '0;
      rsp_bus.ready         = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // start-up with reset zeros in the line, default window
      for (k = 0; k < 10; k++) send_sample('1);
      send_sample('0);
      send_sample(16'd1);
      // zero window saturates to one
      write_window(5'd0);
      send_sample('1);
      send_sample('0);
      send_sample(16'd12345);
      // oversize window saturates to full depth
      write_window(5'd31);
      for (k = 0; k < 4; k++) send_sample(k[0] ? '1 : '0);
      write_window(5'd16);
      send_sample('1);
      send_sample(16'h8000);
      write_window(5'd1);
      send_sample('1);
      send_sample(16'd0);
      send_sample(16'h7FFF);

      sent  = 0;
      phase = 0;
      while (sent < 1400) begin
         write_window(phase < 7 ? corner_windows[phase] : WIN_W'($urandom_range(0, 31)));
         phase_len = $urandom_range(60, 180);
         for (k = 0; k < phase_len && sent < 1400; k++) begin
            if (sent >= 1200) idle_on = 1'b0;
            send_sample(pick_sample());
            sent++;
         end
         phase++;
      end

      drain_averages();
      repeat (64) @(posedge clock);
      $display("Covered %0d checked averages across %0d window settings,", sb.checked,
               windows_used);
      $display("including saturating lengths 0 and 31 and start-up from reset zeros.");
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/twa_pkg.sv
hdl/twa_channels.sv
hdl/twa_front.sv
hdl/twa_queue.sv
hdl/twa_back.sv
hdl/trapezoid_window_average.sv
sim/tb.sv
